@@ src/bmp24_pkg.sv @@
// ----------------------------------------------------------------------------
// bmp24_pkg
// Shared types and constants for the 24-bit bitmap to RGB565 stream decoder.
// ----------------------------------------------------------------------------
package bmp24_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PIXEL     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ORIGIN    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SIGNATURE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FORMAT    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OFFSET    = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_COL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_ROW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd3;

  localparam logic [CFG_W-1:0] RST_ORIGIN_COL    = 16'd0;
  localparam logic [CFG_W-1:0] RST_ORIGIN_ROW    = 16'd0;
  localparam logic [CFG_W-1:0] RST_SCREEN_WIDTH  = 16'd320;
  localparam logic [CFG_W-1:0] RST_SCREEN_HEIGHT = 16'd240;

  // Header byte positions (position of the last byte of each field)
  localparam logic [31:0] POS_SIGNATURE = 32'd1;
  localparam logic [31:0] POS_OFFSET    = 32'd13;
  localparam logic [31:0] POS_WIDTH     = 32'd21;
  localparam logic [31:0] POS_HEIGHT    = 32'd25;
  localparam logic [31:0] POS_FORMAT    = 32'd29;
  localparam logic [31:0] POS_HDR_LAST  = 32'd33;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [15:0] BMP_PLANES    = 16'd1;
  localparam logic [15:0] BMP_BITS      = 16'd24;

  typedef struct packed {
    logic [CFG_W-1:0] origin_col;
    logic [CFG_W-1:0] origin_row;
    logic [CFG_W-1:0] screen_width;
    logic [CFG_W-1:0] screen_height;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] file_byte;
    logic              start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  result_kind;
    logic [COLOR_W-1:0] pixel_color;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
    logic               image_done;
  } result_t;

endpackage

@@ src/bmp24_decode.sv @@
// ----------------------------------------------------------------------------
// bmp24_decode
// Header parser, offset skipper and BGR to RGB565 pixel converter.
// ----------------------------------------------------------------------------
module bmp24_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  bmp24_pkg::in_item_t item,
  input  bmp24_pkg::cfg_t     cfg,
  output logic                res_valid,
  output bmp24_pkg::result_t  res
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_SKIP   = 4'b0100,
    PH_PIXELS = 4'b1000
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] data_offset, data_offset_next;
  logic [31:0] header_word, header_word_next;
  logic [15:0] image_width, image_width_next;
  logic [15:0] image_height, image_height_next;
  logic [31:0] format_fields, format_fields_next;
  logic [15:0] column_count, column_count_next;
  logic [15:0] row_count, row_count_next;
  logic [1:0]  pad_count, pad_count_next;
  logic [1:0]  triple_index, triple_index_next;
  logic [15:0] blue_green, blue_green_next;

  logic [7:0]  b;
  logic [31:0] hw_shift;
  logic [31:0] bp_inc;
  logic [16:0] scol;
  logic [16:0] srow;
  logic [15:0] rows_left;
  logic        last_row;
  logic        last_col;
  logic        visible;
  logic        done;

  assign b         = item.file_byte;
  assign hw_shift  = {b, header_word[31:8]};
  assign bp_inc    = byte_position + 32'd1;
  assign scol      = {1'b0, cfg.origin_col} + {1'b0, column_count};
  assign rows_left = image_height - 16'd1 - row_count;
  assign srow      = {1'b0, cfg.origin_row} + {1'b0, rows_left};
  assign last_row  = ({1'b0, row_count} + 17'd1) == {1'b0, image_height};
  assign last_col  = ({1'b0, column_count} + 17'd1) == {1'b0, image_width};
  assign visible   = (scol < {1'b0, cfg.screen_width}) && (srow < {1'b0, cfg.screen_height});
  assign done      = last_row &&
                     (last_col || (({1'b0, scol} + 18'd1) == {2'b00, cfg.screen_width}));

  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    data_offset_next   = data_offset;
    header_word_next   = header_word;
    image_width_next   = image_width;
    image_height_next  = image_height;
    format_fields_next = format_fields;
    column_count_next  = column_count;
    row_count_next     = row_count;
    pad_count_next     = pad_count;
    triple_index_next  = triple_index;
    blue_green_next    = blue_green;
    res_valid          = 1'b0;
    res                = '0;
    res.image_done     = 1'b1;

    if (fire) begin
      if (item.start_of_file) begin
        phase_next         = PH_HEADER;
        byte_position_next = '0;
        header_word_next   = {b, 24'h000000};
        data_offset_next   = '0;
        image_width_next   = '0;
        image_height_next  = '0;
        format_fields_next = '0;
        if (cfg.origin_col >= cfg.screen_width || cfg.origin_row >= cfg.screen_height) begin
          phase_next      = PH_IDLE;
          res_valid       = 1'b1;
          res.result_kind = bmp24_pkg::KIND_ORIGIN;
        end
      end else begin
        unique case (phase)
          PH_HEADER: begin
            byte_position_next = bp_inc;
            header_word_next   = hw_shift;
            priority if (bp_inc == bmp24_pkg::POS_SIGNATURE) begin
              if (hw_shift[31:16] != bmp24_pkg::BMP_SIGNATURE) begin
                phase_next      = PH_IDLE;
                res_valid       = 1'b1;
                res.result_kind = bmp24_pkg::KIND_SIGNATURE;
              end
            end else if (bp_inc == bmp24_pkg::POS_OFFSET) begin
              data_offset_next = hw_shift;
            end else if (bp_inc == bmp24_pkg::POS_WIDTH) begin
              image_width_next = hw_shift[15:0];
            end else if (bp_inc == bmp24_pkg::POS_HEIGHT) begin
              image_height_next = hw_shift[15:0];
            end else if (bp_inc == bmp24_pkg::POS_FORMAT) begin
              format_fields_next = hw_shift;
            end else if (bp_inc == bmp24_pkg::POS_HDR_LAST) begin
              priority if (format_fields[15:0] != bmp24_pkg::BMP_PLANES ||
                           format_fields[31:16] != bmp24_pkg::BMP_BITS ||
                           hw_shift != 32'd0) begin
                phase_next      = PH_IDLE;
                res_valid       = 1'b1;
                res.result_kind = bmp24_pkg::KIND_FORMAT;
              end else if (data_offset <= bmp24_pkg::POS_HDR_LAST) begin
                phase_next      = PH_IDLE;
                res_valid       = 1'b1;
                res.result_kind = bmp24_pkg::KIND_OFFSET;
              end else begin
                column_count_next = '0;
                row_count_next    = '0;
                pad_count_next    = '0;
                triple_index_next = '0;
                blue_green_next   = '0;
                priority if (image_width == 16'd0 || image_height == 16'd0) begin
                  phase_next = PH_IDLE;
                end else if (data_offset == bmp24_pkg::POS_HDR_LAST + 32'd1) begin
                  phase_next = PH_PIXELS;
                end else begin
                  phase_next = PH_SKIP;
                end
              end
            end else begin
              phase_next = phase;
            end
          end
          PH_SKIP: begin
            byte_position_next = bp_inc;
            if (({1'b0, bp_inc} + 33'd1) >= {1'b0, data_offset}) begin
              phase_next = PH_PIXELS;
            end
          end
          PH_PIXELS: begin
            priority if (pad_count != 2'd0) begin
              pad_count_next = pad_count - 2'd1;
              if (pad_count == 2'd1) begin
                row_count_next = row_count + 16'd1;
              end
            end else if (triple_index == 2'd0) begin
              blue_green_next   = {8'h00, b};
              triple_index_next = 2'd1;
            end else if (triple_index == 2'd1) begin
              blue_green_next   = {b, blue_green[7:0]};
              triple_index_next = 2'd2;
            end else begin
              triple_index_next = 2'd0;
              res_valid         = visible;
              res.result_kind   = bmp24_pkg::KIND_PIXEL;
              res.pixel_color   = {b[7:3], blue_green[15:10], blue_green[7:3]};
              res.pixel_col     = scol[15:0];
              res.pixel_row     = srow[15:0];
              res.image_done    = done;
              column_count_next = column_count + 16'd1;
              if (last_col) begin
                column_count_next = '0;
                priority if (last_row) begin
                  phase_next = PH_IDLE;
                end else if (image_width[1:0] != 2'd0) begin
                  pad_count_next = image_width[1:0];
                end else begin
                  row_count_next = row_count + 16'd1;
                end
              end
            end
          end
          PH_IDLE: begin
            phase_next = PH_IDLE;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_position <= '0;
      data_offset   <= '0;
      header_word   <= '0;
      image_width   <= '0;
      image_height  <= '0;
      format_fields <= '0;
      column_count  <= '0;
      row_count     <= '0;
      pad_count     <= '0;
      triple_index  <= '0;
      blue_green    <= '0;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      data_offset   <= data_offset_next;
      header_word   <= header_word_next;
      image_width   <= image_width_next;
      image_height  <= image_height_next;
      format_fields <= format_fields_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      pad_count     <= pad_count_next;
      triple_index  <= triple_index_next;
      blue_green    <= blue_green_next;
    end
  end

  a_err_goes_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid && res.result_kind != bmp24_pkg::KIND_PIXEL |=> phase == PH_IDLE)
    else $error("error result did not return the parser to idle");

  a_err_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.result_kind != bmp24_pkg::KIND_PIXEL |-> res.image_done)
    else $error("error result without image_done");

  a_triple_range: assert property (@(posedge clk) disable iff (rst)
    triple_index != 2'd3)
    else $error("triple index out of range");

  a_header_pos: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> byte_position < bmp24_pkg::POS_HDR_LAST)
    else $error("header parse ran past its last byte");

endmodule

@@ src/bmp24_out_stage.sv @@
// ----------------------------------------------------------------------------
// bmp24_out_stage
// Result register driving the master stream and packing its payload.
// ----------------------------------------------------------------------------
module bmp24_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               res_valid,
  input  bmp24_pkg::result_t res,
  output logic               free,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [47:0]        m_axis_tdata,
  output logic [2:0]         m_axis_tuser,
  output logic               m_axis_tlast
);

  logic               out_valid;
  bmp24_pkg::result_t out_res;

  assign free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res_valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.pixel_row, out_res.pixel_col, out_res.pixel_color};
  assign m_axis_tuser  = out_res.result_kind;
  assign m_axis_tlast  = out_res.image_done;

endmodule

@@ src/bmp24_stream_to_rgb565.sv @@
// ----------------------------------------------------------------------------
// bmp24_stream_to_rgb565
// Streams a 24-bit bitmap file byte by byte and emits cropped RGB565 pixels.
// ----------------------------------------------------------------------------
// Path: an accepted byte waits in the input register; its result then goes to
// the result register and is offered on the master side. Throughput: 1 file
// byte per cycle unless m_axis_tready stalls; each byte takes a single pass.
// Reset (synchronous, rst high): parser idle, stream registers empty,
// origin 0/0 and screen 320 x 240.
module bmp24_stream_to_rgb565 (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] file_byte
  input  logic        s_axis_tuser,   // [0] start_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] pixel_color, [31:16] pixel_col,
                                      // [47:32] pixel_row
  output logic [2:0]  m_axis_tuser,   // [2:0] result_kind
  output logic        m_axis_tlast    // image_done
);

  bmp24_pkg::cfg_t     cfg;
  bmp24_pkg::in_item_t in_item;
  bmp24_pkg::result_t  res;
  logic                in_valid;
  logic                out_free;
  logic                fire;
  logic                res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_col    <= bmp24_pkg::RST_ORIGIN_COL;
      cfg.origin_row    <= bmp24_pkg::RST_ORIGIN_ROW;
      cfg.screen_width  <= bmp24_pkg::RST_SCREEN_WIDTH;
      cfg.screen_height <= bmp24_pkg::RST_SCREEN_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmp24_pkg::CFG_ORIGIN_COL:    cfg.origin_col    <= cfg_data;
        bmp24_pkg::CFG_ORIGIN_ROW:    cfg.origin_row    <= cfg_data;
        bmp24_pkg::CFG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data;
        bmp24_pkg::CFG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data;
        default:                      cfg.origin_col    <= cfg.origin_col;
      endcase
    end
  end

  assign fire          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.file_byte     <= s_axis_tdata;
      in_item.start_of_file <= s_axis_tuser;
    end
  end

  bmp24_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (in_item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  bmp24_out_stage u_out_stage (
    .clk           (clk),
    .rst           (rst),
    .load          (fire),
    .res_valid     (res_valid),
    .res           (res),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
